### rtl/pcv_pkg.sv
// ----------------------------------------------------------------------------
// pcv_pkg
// Shared widths, register indexes and helpers for the Verlet chain block.
// ----------------------------------------------------------------------------
package pcv_pkg;

   localparam int MaxNodesDefault = 16;
   localparam int PosWidth        = 32;
   localparam int IndexWidth      = 4;
   localparam int CsrIndexWidth   = 3;
   localparam int CsrDataWidth    = 32;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_NODE_COUNT     = 3'd0,
      CSR_SEGMENT_LENGTH = 3'd1,
      CSR_PIVOT_X        = 3'd2,
      CSR_PIVOT_Y        = 3'd3,
      CSR_GRAVITY_STEP   = 3'd4,
      CSR_DRAG_OVER_MASS = 3'd5
   } csr_index_type;

   // Clamp a signed 66-bit value to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [65:0] hi;
      logic signed [65:0] lo;
      hi = 66'sd2147483647;
      lo = -66'sd2147483648;
      if (v > hi) begin
         return 32'sh7fffffff;
      end else if (v < lo) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

### rtl/pcv_divider.sv
// ----------------------------------------------------------------------------
// pcv_divider
// Radix-2 restoring divider, 64-bit dividend by 64-bit divisor, one quotient
// bit per cycle. Shared for the square root as well (bit-pair restoring).
// ----------------------------------------------------------------------------
module pcv_divider
   import pcv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        sqrt_mode,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic        done,
   output logic [63:0] quo
);

   logic [6:0]  cnt_ff,  cnt_in;
   logic        busy_ff, busy_in;
   logic        mode_ff, mode_in;
   logic [63:0] q_ff,    q_in;
   logic [65:0] r_ff,    r_in;
   logic [63:0] n_ff,    n_in;
   logic [63:0] d_ff,    d_in;
   logic        done_ff, done_in;

   logic [65:0] rsh;
   logic [65:0] trial;

   // One division or root step.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      mode_in = mode_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      n_in    = n_ff;
      d_in    = d_ff;
      done_in = 1'b0;
      rsh     = '0;
      trial   = '0;
      if (start) begin
         busy_in = 1'b1;
         mode_in = sqrt_mode;
         cnt_in  = sqrt_mode ? 7'd32 : 7'd64;
         q_in    = '0;
         r_in    = '0;
         n_in    = num;
         d_in    = den;
      end else if (busy_ff) begin
         if (mode_ff) begin
            rsh   = {r_ff[63:0], n_ff[63:62]};
            trial = {q_ff[63:0], 2'b01};
            n_in  = {n_ff[61:0], 2'b00};
         end else begin
            rsh   = {r_ff[64:0], n_ff[63]};
            trial = {2'b00, d_ff};
            n_in  = {n_ff[62:0], 1'b0};
         end
         if (rsh >= trial) begin
            r_in = rsh - trial;
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = rsh;
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mode_ff <= mode_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
      n_ff    <= n_in;
      d_ff    <= d_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

### rtl/pendulum_chain_verlet_step.sv
// ----------------------------------------------------------------------------
// pendulum_chain_verlet_step
// Chain of point masses advanced by position Verlet with distance limits.
// ----------------------------------------------------------------------------
// A load item writes one node and gives no result. A tick item runs a
// sequencer over one shared 32x32 multiplier and one shared divide/root
// unit. Each node gets a Verlet update of x and then y. Each of the n
// constraints (pivot to node 0, then each neighbouring pair) takes a square
// root, and when the distance exceeds the segment length, two divides too.
// The n results then go out one per cycle as the sink takes them. The block
// accepts no item while a tick is in progress.
module pendulum_chain_verlet_step
   import pcv_pkg::*;
#(
   parameter int MAX_NODES = MaxNodesDefault
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_mode,
   input  logic [IndexWidth-1:0]    req_node_index,
   input  logic signed [31:0]       req_load_x,
   input  logic signed [31:0]       req_load_y,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [IndexWidth-1:0]    rsp_out_index,
   output logic signed [31:0]       rsp_out_x,
   output logic signed [31:0]       rsp_out_y,
   output logic                     rsp_last,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int LIM = (MAX_NODES < 16) ? MAX_NODES : 16;

   typedef enum logic [4:0] {
      S_IDLE, S_VRD, S_VDX, S_VM1, S_VM2, S_VWX, S_VM3, S_VM4, S_VWY,
      S_CRD, S_CSQ1, S_CSQ2, S_CRT, S_CRTW, S_CMX, S_CDX, S_CDXW, S_CMY,
      S_CDY, S_CDYW, S_CWR, S_CWR2, S_OUT
   } state_type;

   // configuration
   logic [4:0]         ncount_ff;
   logic [30:0]        seg_ff;
   logic signed [31:0] pivx_ff, pivy_ff;
   logic [23:0]        grav_ff, drag_ff;

   // node memories
   logic signed [31:0] cx_mem [MAX_NODES];
   logic signed [31:0] cy_mem [MAX_NODES];
   logic signed [31:0] ox_mem [MAX_NODES];
   logic signed [31:0] oy_mem [MAX_NODES];

   state_type          state_ff;
   logic [NW-1:0]      idx_ff;
   logic [CW-1:0]      n_ff;
   logic               pivot_ff;
   logic               axis_ff;
   logic signed [31:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [33:0] d_ff;
   logic signed [33:0] ddx_ff, ddy_ff;
   logic [63:0]        acc_ff;
   logic [31:0]        f_ff;
   logic [47:0]        t_ff;
   logic [63:0]        dist_ff;
   logic signed [33:0] sx_ff;

   // shared multiplier, registered product
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [63:0] prod_ff;

   // shared divide / root unit
   logic        dv_start, dv_sqrt, dv_done;
   logic [63:0] dv_num, dv_den, dv_quo;

   pcv_divider u_div (
      .clock(clock), .reset(reset), .start(dv_start), .sqrt_mode(dv_sqrt),
      .num(dv_num), .den(dv_den), .done(dv_done), .quo(dv_quo)
   );

   logic [CW-1:0] ncap;
   logic [33:0]   ad;
   logic [33:0]   adx, ady;
   logic [64:0]   sumsq;
   logic signed [33:0] scaled;
   logic signed [34:0] corr;
   logic signed [33:0] half;
   logic signed [48:0] term;
   logic signed [65:0] vnew;

   always_comb begin
      if (ncount_ff > 5'(LIM)) ncap = CW'(LIM);
      else                     ncap = CW'(ncount_ff);
   end

   assign ad    = d_ff[33] ? 34'(-d_ff) : 34'(d_ff);
   assign adx   = ddx_ff[33] ? 34'(-ddx_ff) : 34'(ddx_ff);
   assign ady   = ddy_ff[33] ? 34'(-ddy_ff) : 34'(ddy_ff);
   assign sumsq = {1'b0, acc_ff} + {1'b0, prod_ff};
   assign scaled = (axis_ff ? ddy_ff[33] : ddx_ff[33]) ? -34'(dv_quo) : 34'(dv_quo);
   assign corr  = 35'(axis_ff ? ddy_ff : ddx_ff) - 35'(scaled);
   assign half  = 34'(corr / 35'sd2);

   // drag term with the sign of the step, and the updated coordinate
   assign term = d_ff[33] ? -$signed({1'b0, t_ff}) : $signed({1'b0, t_ff});
   assign vnew = (axis_ff ? 66'(ay_ff) + 66'($signed({1'b0, grav_ff})) : 66'(ax_ff))
                 + 66'(d_ff) - 66'(term);

   // select multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_VM1:   begin mul_a = {8'd0, drag_ff}; mul_b = ad[31:0]; end
         S_VM3:   begin mul_a = f_ff; mul_b = ad[31:0]; end
         S_CSQ1:  begin mul_a = adx[31:0]; mul_b = adx[31:0]; end
         S_CSQ2:  begin mul_a = ady[31:0]; mul_b = ady[31:0]; end
         S_CMX:   begin mul_a = adx[31:0]; mul_b = {1'b0, seg_ff}; end
         S_CMY:   begin mul_a = ady[31:0]; mul_b = {1'b0, seg_ff}; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_out_index = IndexWidth'(idx_ff);
   assign rsp_out_x = ax_ff;
   assign rsp_out_y = ay_ff;
   assign rsp_last  = (CW'(idx_ff) + CW'(1) == n_ff);

   always_comb begin
      dv_start = 1'b0;
      dv_sqrt  = 1'b0;
      dv_num   = '0;
      dv_den   = dist_ff;
      case (state_ff)
         S_CRT: begin
            dv_start = 1'b1; dv_sqrt = 1'b1;
            dv_num = sumsq[64] ? 64'hffffffffffffffff : sumsq[63:0];
         end
         S_CDX, S_CDY: begin
            dv_start = 1'b1;
            dv_num = prod_ff;
         end
         default: dv_start = 1'b0;
      endcase
   end

   // sequencer, datapath registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ncount_ff <= 5'd1;
         seg_ff    <= 31'd6553600;
         pivx_ff   <= '0;
         pivy_ff   <= 32'sd3276800;
         grav_ff   <= 24'd16442;
         drag_ff   <= 24'd167772;
      end else begin
         prod_ff <= mul_p;
         case (state_ff)
            S_IDLE: begin
               if (csr_valid) begin
                  case (csr_index)
                     CSR_NODE_COUNT:     ncount_ff <= csr_data[4:0];
                     CSR_SEGMENT_LENGTH: seg_ff    <= csr_data[30:0];
                     CSR_PIVOT_X:        pivx_ff   <= csr_data;
                     CSR_PIVOT_Y:        pivy_ff   <= csr_data;
                     CSR_GRAVITY_STEP:   grav_ff   <= csr_data[23:0];
                     CSR_DRAG_OVER_MASS: drag_ff   <= csr_data[23:0];
                     default: ;
                  endcase
               end
               if (req_valid) begin
                  if (!req_mode) begin
                     if (int'(req_node_index) < MAX_NODES) begin
                        cx_mem[NW'(req_node_index)] <= req_load_x;
                        ox_mem[NW'(req_node_index)] <= req_load_x;
                        cy_mem[NW'(req_node_index)] <= req_load_y;
                        oy_mem[NW'(req_node_index)] <= req_load_y;
                     end
                  end else if (ncap != '0) begin
                     n_ff     <= ncap;
                     idx_ff   <= '0;
                     state_ff <= S_VRD;
                  end
               end
            end
            // read node, form x step
            S_VRD: begin
               ax_ff    <= cx_mem[idx_ff];
               ay_ff    <= cy_mem[idx_ff];
               bx_ff    <= ox_mem[idx_ff];
               by_ff    <= oy_mem[idx_ff];
               axis_ff  <= 1'b0;
               state_ff <= S_VDX;
            end
            S_VDX: begin
               d_ff <= axis_ff ? 34'(ay_ff) - 34'(by_ff) : 34'(ax_ff) - 34'(bx_ff);
               state_ff <= S_VM1;
            end
            S_VM1: state_ff <= S_VM2;
            S_VM2: begin
               f_ff     <= prod_ff[55:24];
               state_ff <= S_VM3;
            end
            S_VM3: state_ff <= S_VM4;
            S_VM4: begin
               t_ff <= prod_ff[63:16];
               if (axis_ff) state_ff <= S_VWY;
               else         state_ff <= S_VWX;
            end
            S_VWX: begin
               ox_mem[idx_ff] <= ax_ff;
               cx_mem[idx_ff] <= sat32(vnew);
               axis_ff  <= 1'b1;
               state_ff <= S_VDX;
            end
            S_VWY: begin
               oy_mem[idx_ff] <= ay_ff;
               cy_mem[idx_ff] <= sat32(vnew);
               if (CW'(idx_ff) + CW'(1) == n_ff) begin
                  idx_ff   <= '0;
                  pivot_ff <= 1'b1;
                  state_ff <= S_CRD;
               end else begin
                  idx_ff   <= idx_ff + NW'(1);
                  state_ff <= S_VRD;
               end
            end
            // constraint: pivot-node0 or node i to i+1
            S_CRD: begin
               if (pivot_ff) begin
                  ax_ff  <= pivx_ff;
                  ay_ff  <= pivy_ff;
                  bx_ff  <= cx_mem[0];
                  by_ff  <= cy_mem[0];
                  ddx_ff <= 34'(cx_mem[0]) - 34'(pivx_ff);
                  ddy_ff <= 34'(cy_mem[0]) - 34'(pivy_ff);
               end else begin
                  ax_ff  <= cx_mem[idx_ff];
                  ay_ff  <= cy_mem[idx_ff];
                  bx_ff  <= cx_mem[idx_ff + NW'(1)];
                  by_ff  <= cy_mem[idx_ff + NW'(1)];
                  ddx_ff <= 34'(cx_mem[idx_ff + NW'(1)]) - 34'(cx_mem[idx_ff]);
                  ddy_ff <= 34'(cy_mem[idx_ff + NW'(1)]) - 34'(cy_mem[idx_ff]);
               end
               state_ff <= S_CSQ1;
            end
            S_CSQ1: state_ff <= S_CSQ2;
            S_CSQ2: begin
               acc_ff   <= prod_ff;
               state_ff <= S_CRT;
            end
            S_CRT: state_ff <= S_CRTW;
            S_CRTW: begin
               if (dv_done) begin
                  dist_ff <= dv_quo;
                  if (dv_quo > 64'(seg_ff)) begin
                     axis_ff  <= 1'b0;
                     state_ff <= S_CMX;
                  end else begin
                     state_ff <= S_CWR2;
                  end
               end
            end
            // scale x: |dx| * segment, then divide by the distance
            S_CMX: state_ff <= S_CDX;
            S_CDX: state_ff <= S_CDXW;
            S_CDXW: begin
               if (dv_done) begin
                  sx_ff    <= pivot_ff ? scaled : half;
                  axis_ff  <= 1'b1;
                  state_ff <= S_CMY;
               end
            end
            // scale y the same way
            S_CMY: state_ff <= S_CDY;
            S_CDY: state_ff <= S_CDYW;
            S_CDYW: begin
               if (dv_done) state_ff <= S_CWR;
            end
            // write back: node 0 to pivot plus scaled step, or split halves
            S_CWR: begin
               if (pivot_ff) begin
                  cx_mem[0] <= sat32(66'(ax_ff) + 66'(sx_ff));
                  cy_mem[0] <= sat32(66'(ay_ff) + 66'(scaled));
               end else begin
                  cx_mem[idx_ff + NW'(1)] <= sat32(66'(bx_ff) - 66'(sx_ff));
                  cy_mem[idx_ff + NW'(1)] <= sat32(66'(by_ff) - 66'(half));
                  cx_mem[idx_ff] <= sat32(66'(ax_ff) + 66'(sx_ff));
                  cy_mem[idx_ff] <= sat32(66'(ay_ff) + 66'(half));
               end
               state_ff <= S_CWR2;
            end
            S_CWR2: begin
               if (pivot_ff && n_ff > CW'(1)) begin
                  pivot_ff <= 1'b0;
                  idx_ff   <= '0;
                  state_ff <= S_CRD;
               end else if (!pivot_ff && CW'(idx_ff) + CW'(2) < n_ff) begin
                  idx_ff   <= idx_ff + NW'(1);
                  state_ff <= S_CRD;
               end else begin
                  // chain settled: present node 0
                  pivot_ff <= 1'b0;
                  idx_ff   <= '0;
                  ax_ff    <= cx_mem[0];
                  ay_ff    <= cy_mem[0];
                  state_ff <= S_OUT;
               end
            end
            // report nodes, advance on each accepted item
            S_OUT: begin
               if (rsp_ready) begin
                  if (CW'(idx_ff) + CW'(1) == n_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff <= idx_ff + NW'(1);
                     ax_ff  <= cx_mem[idx_ff + NW'(1)];
                     ay_ff  <= cy_mem[idx_ff + NW'(1)];
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

### tb/sv/tb_pendulum_chain_verlet_step.sv
// ----------------------------------------------------------------------------
// tb_pendulum_chain_verlet_step
// Random and directed test of the Verlet chain block: loads nodes, ticks the
// chain under several register settings and checks every reported position
// against a bit-exact predictor held in a scoreboard class.
// ----------------------------------------------------------------------------
module tb_pendulum_chain_verlet_step
   import pcv_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Nodes      = 16;
   localparam int CycleLimit = 10000000;

   typedef struct packed {
      logic [3:0]         index;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic               last;
   } node_report_type;

   // Chain predictor and queue of expected node reports.
   class chain_scoreboard;
      logic [4:0]          count;
      logic [30:0]         seg;
      longint              piv_x, piv_y;
      logic [23:0]         grav, drag;
      longint              px[Nodes], py[Nodes], qx[Nodes], qy[Nodes];
      node_report_type     pending[$];
      int                  errors;
      int                  reports;

      function void init();
         count = 1; seg = 31'd6553600; piv_x = 0; piv_y = 3276800;
         grav = 24'd16442; drag = 24'd167772; errors = 0; reports = 0;
         for (int i = 0; i < Nodes; i++) begin
            px[i] = 0; py[i] = 0; qx[i] = 0; qy[i] = 0;
         end
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] v);
         case (idx)
            CSR_NODE_COUNT: count = v[4:0];
            CSR_SEGMENT_LENGTH: seg = v[30:0];
            CSR_PIVOT_X: piv_x = longint'($signed(v));
            CSR_PIVOT_Y: piv_y = longint'($signed(v));
            CSR_GRAVITY_STEP: grav = v[23:0];
            CSR_DRAG_OVER_MASS: drag = v[23:0];
            default: ;
         endcase
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function logic [63:0] absval(longint v);
         return v < 0 ? -v : v;
      endfunction

      function logic [63:0] root64(logic [63:0] n);
         logic [63:0] r, b;
         r = 0; b = 64'd1 << 62;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n = n - (r + b); r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function logic [63:0] span(longint dx, longint dy);
         logic [63:0] sx, sy, s;
         sx = absval(dx) * absval(dx);
         sy = absval(dy) * absval(dy);
         s = sx + sy;
         if (s < sx) s = '1;
         return root64(s);
      endfunction

      function longint shrink(longint a, logic [63:0] d);
         logic [63:0] m;
         m = (absval(a) * 64'(seg)) / d;
         return a < 0 ? -longint'(m) : longint'(m);
      endfunction

      function longint advance(longint p, longint q, longint push);
         longint d, term;
         logic [63:0] ad, f, t;
         d = p - q; ad = absval(d);
         f = (64'(drag) * ad) >> 24;
         t = (f * ad) >> 16;
         term = d < 0 ? -longint'(t) : longint'(t);
         return clamp32(p + d + push - term);
      endfunction

      // Apply one accepted input item.
      function void note_item(logic mode, logic [3:0] k, logic [31:0] lx, logic [31:0] ly);
         int n;
         longint nx, ny, dx, dy, hx, hy;
         logic [63:0] d;
         node_report_type r;
         if (!mode) begin
            px[k] = longint'($signed(lx)); qx[k] = px[k];
            py[k] = longint'($signed(ly)); qy[k] = py[k];
            return;
         end
         n = count > Nodes ? Nodes : count;
         if (n == 0) return;
         for (int i = 0; i < n; i++) begin
            nx = advance(px[i], qx[i], 0);
            ny = advance(py[i], qy[i], longint'(grav));
            qx[i] = px[i]; qy[i] = py[i]; px[i] = nx; py[i] = ny;
         end
         dx = px[0] - piv_x; dy = py[0] - piv_y;
         d = span(dx, dy);
         if (d > 64'(seg)) begin
            px[0] = clamp32(piv_x + shrink(dx, d));
            py[0] = clamp32(piv_y + shrink(dy, d));
         end
         for (int i = 0; i + 1 < n; i++) begin
            dx = px[i+1] - px[i]; dy = py[i+1] - py[i];
            d = span(dx, dy);
            if (d > 64'(seg)) begin
               hx = (dx - shrink(dx, d)) / 2;
               hy = (dy - shrink(dy, d)) / 2;
               px[i+1] = clamp32(px[i+1] - hx); py[i+1] = clamp32(py[i+1] - hy);
               px[i] = clamp32(px[i] + hx); py[i] = clamp32(py[i] + hy);
            end
         end
         for (int i = 0; i < n; i++) begin
            r.index = i[3:0]; r.x = px[i][31:0]; r.y = py[i][31:0];
            r.last = (i + 1 == n);
            pending.insert(pending.size(), r);
         end
      endfunction

      // Compare one accepted result with the oldest expectation.
      function void check_report(node_report_type got);
         node_report_type e;
         reports++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected report idx=%0d x=%0d y=%0d", $time,
                     got.index, got.x, got.y);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.index !== e.index) begin
            $display("%0t: out_index expected %0d got %0d", $time, e.index, got.index);
            errors++;
         end
         if (got.x !== e.x) begin
            $display("%0t: out_x expected %0d got %0d", $time, e.x, got.x);
            errors++;
         end
         if (got.y !== e.y) begin
            $display("%0t: out_y expected %0d got %0d", $time, e.y, got.y);
            errors++;
         end
         if (got.last !== e.last) begin
            $display("%0t: last expected %0d got %0d", $time, e.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready, req_mode = 0;
   logic [3:0] req_node_index = 0;
   logic signed [31:0] req_load_x = 0, req_load_y = 0;
   logic rsp_valid, rsp_ready = 0, rsp_last;
   logic [3:0] rsp_out_index;
   logic signed [31:0] rsp_out_x, rsp_out_y;
   logic csr_valid = 0, csr_ready;
   logic [2:0] csr_index = 0;
   logic [31:0] csr_data = 0;

   chain_scoreboard chain = new();
   int sink_idle_pct = 0;
   int cycles = 0;
   logic [15:0] loaded = 0;
   int ticks = 0;

   pendulum_chain_verlet_step dut (.*);

   always #2 clock = ~clock;

   // Abort on runaway.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Check results at the rising edge; drive the sink stall at the falling edge.
   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         chain.check_report('{rsp_out_index, rsp_out_x, rsp_out_y, rsp_last});

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= sink_idle_pct);

   task automatic write_csr(csr_index_type idx, logic [31:0] v);
      @(negedge clock);
      csr_valid <= 1; csr_index <= idx; csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      chain.write_reg(idx, v);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // Send one item, idling first with the given percentage.
   task automatic send_item(int idle_pct, logic mode, logic [3:0] k,
                            logic [31:0] lx, logic [31:0] ly);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1; req_mode <= mode; req_node_index <= k;
      req_load_x <= lx; req_load_y <= ly;
      do @(posedge clock); while (!req_ready);
      chain.note_item(mode, k, lx, ly);
      if (!mode) loaded[k] = 1'b1;
      else ticks++;
   endtask

   task automatic release_req();
      @(negedge clock);
      req_valid <= 0;
   endtask

   // Drain expectations, then let the block settle before register writes.
   task automatic drain();
      release_req();
      while (chain.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic load_all(int idle_pct, int span);
      for (int i = 0; i < Nodes; i++)
         send_item(idle_pct, 1'b0, i[3:0], $urandom_range(2 * span) - span,
                   $urandom_range(2 * span) - span);
   endtask

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(1 << 24) - (1 << 23);
         2: return $urandom_range(8) ? 32'h7fffffff - $urandom_range(99)
                                     : 32'h80000000 + $urandom_range(99);
         default: return $urandom_range(1 << 22) - (1 << 21);
      endcase
   endfunction

   // Random part under one setting of the registers.
   task automatic random_phase(int items, int src_pct, int snk_pct);
      sink_idle_pct = snk_pct;
      write_csr(CSR_NODE_COUNT, $urandom_range(3) == 0 ? $urandom_range(16) :
                $urandom_range(4, 1));
      write_csr(CSR_SEGMENT_LENGTH, $urandom_range(3) == 0 ? $urandom :
                $urandom_range(40 << 16, 1 << 16));
      write_csr(CSR_PIVOT_X, $urandom_range(1) ? $urandom : $urandom_range(1 << 22));
      write_csr(CSR_PIVOT_Y, $urandom_range(1) ? $urandom : $urandom_range(1 << 22));
      write_csr(CSR_GRAVITY_STEP, $urandom_range(24'hffffff));
      write_csr(CSR_DRAG_OVER_MASS, $urandom_range(1) ? $urandom_range(24'hffffff) :
                $urandom_range(1 << 18));
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(9) < 3)
            send_item(src_pct, 1'b0, 4'($urandom_range(15)), rand_pos(), rand_pos());
         else
            send_item(src_pct, 1'b1, 4'd0, $urandom, $urandom);
         if (i == items / 2) begin
            // Hold off until the block has reported everything.
            release_req();
            while (chain.pending.size() != 0) @(posedge clock);
         end
      end
      drain();
   endtask

   initial begin
      chain.init();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: reset registers, extremes, count of zero and out-of-range counts.
      sink_idle_pct = 0;
      load_all(0, 1 << 20);
      send_item(0, 1'b0, 4'd15, 32'h7fffffff, 32'h80000000);
      send_item(0, 1'b1, 4'd3, 32'h80000000, 32'h7fffffff);
      send_item(0, 1'b1, 4'd0, 32'd0, 32'd0);
      drain();
      write_csr(CSR_NODE_COUNT, 32'd16);
      write_csr(CSR_SEGMENT_LENGTH, 32'h7fffffff);
      write_csr(CSR_PIVOT_X, 32'h80000000);
      write_csr(CSR_PIVOT_Y, 32'h7fffffff);
      write_csr(CSR_GRAVITY_STEP, 32'hffffff);
      write_csr(CSR_DRAG_OVER_MASS, 32'hffffff);
      send_item(0, 1'b0, 4'd0, 32'h7fffffff, 32'h7fffffff);
      send_item(0, 1'b0, 4'd1, 32'h80000000, 32'h80000000);
      send_item(0, 1'b1, 4'd15, 32'hffffffff, 32'hffffffff);
      send_item(0, 1'b1, 4'd0, 32'd0, 32'd0);
      drain();
      write_csr(CSR_SEGMENT_LENGTH, 32'd0);
      write_csr(CSR_DRAG_OVER_MASS, 32'd0);
      write_csr(CSR_GRAVITY_STEP, 32'd0);
      send_item(0, 1'b1, 4'd0, 32'd0, 32'd0);
      drain();
      write_csr(CSR_NODE_COUNT, 32'd0);
      send_item(0, 1'b1, 4'd0, 32'd0, 32'd0);
      drain();
      write_csr(CSR_NODE_COUNT, 32'd31);
      send_item(0, 1'b1, 4'd0, 32'd0, 32'd0);
      drain();

      // Random phases across the three idling patterns.
      for (int p = 0; p < 9; p++)
         random_phase(17, 10, 46);
      for (int p = 0; p < 9; p++)
         random_phase(17, 46, 10);
      for (int p = 0; p < 9; p++)
         random_phase(17, 0, 0);

      $display("Covered %0d ticks and %0d node reports; loaded nodes mask %h.",
               ticks, chain.reports, loaded);
      if (chain.errors == 0 && chain.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

### pendulum_chain_verlet_step.f
rtl/pcv_pkg.sv
rtl/pcv_divider.sv
rtl/pendulum_chain_verlet_step.sv
tb/sv/tb_pendulum_chain_verlet_step.sv
